@@ rtl/core/thresholded_all_pairs_shortest_path_unit_defines.svh @@
// Assertion macros shared by the thresholded shortest path unit.
`ifndef THRESHOLDED_ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH
`define THRESHOLDED_ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH

// Plain property, sampled on clk_i and disabled while rst_ni is low.
`define TAPSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication: whenever ante holds, cons holds in the same cycle.
`define TAPSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tapsp_pkg.sv @@
// Shared constants, codes and types of the thresholded shortest path unit.
package tapsp_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_DIST_BITS = 16;

  localparam int REQ_W      = 2;
  localparam int NODE_IDX_W = 6;
  localparam int LEN_W      = 16;
  localparam int OUT_DIST_W = 16;
  localparam int NCOUNT_W   = 7;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 32;
  localparam int SRC_LSB    = 0;
  localparam int DST_LSB    = SRC_LSB + NODE_IDX_W;
  localparam int LEN_LSB    = DST_LSB + NODE_IDX_W;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [THRESH_W-1:0] THRESH_RST     = 16'd256;
  localparam int                  SHORT_EDGE_LIMIT = 258;
  localparam logic [OUT_DIST_W-1:0] OUT_DIST_INF = '1;

  localparam logic BANK_SHORT = 1'b0;
  localparam logic BANK_REACH = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT      = 1'b0,
    CFG_REACH_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ADD1,
    ST_ADD2,
    ST_SEED1,
    ST_SEED2,
    ST_FETCH,
    ST_ROW,
    ST_QUERY
  } seq_state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_INIT,
    DP_CLEAR,
    DP_ADD,
    DP_SEED1,
    DP_SEED2,
    DP_FETCH,
    DP_RELAX,
    DP_QUERY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   bank;
    logic   in_range;
  } dp_ctrl_t;

  typedef struct packed {
    logic                  valid;
    logic [OUT_DIST_W-1:0] distance;
    logic                  reachable;
  } dp_result_t;

endpackage

@@ rtl/core/tapsp_seq.sv @@
// Sequencer: request decode, sweep and triple-loop counters, datapath control.
`include "thresholded_all_pairs_shortest_path_unit_defines.svh"

module tapsp_seq #(
  parameter int MAX_NODES = tapsp_pkg::DEF_MAX_NODES,
  parameter int NODE_W    = $clog2(MAX_NODES),
  parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tapsp_pkg::REQ_W-1:0]      req_i,
  input  logic [tapsp_pkg::NODE_IDX_W-1:0] src_i,
  input  logic [tapsp_pkg::NODE_IDX_W-1:0] dst_i,
  input  logic [tapsp_pkg::LEN_W-1:0]      len_i,
  input  logic [CNT_W-1:0]                 n_i,
  input  logic                            out_stall_i,
  output tapsp_pkg::dp_ctrl_t              ctrl_o,
  output logic [NODE_W-1:0]                row_o,
  output logic [NODE_W-1:0]                col_o,
  output logic [NODE_W-1:0]                piv_o,
  output logic [tapsp_pkg::LEN_W-1:0]      len_o
);
  import tapsp_pkg::*;

  localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MAX_NODES - 1);

  seq_state_e state_q, state_d;
  logic [NODE_W-1:0] row_q, row_d, col_q, col_d, piv_q, piv_d;
  logic bank_q, bank_d;
  logic [NODE_IDX_W-1:0] a_q, b_q;
  logic [LEN_W-1:0] len_q;
  logic ok_q;

  logic accept, src_ok, dst_ok;
  logic last_col_m, last_row_m, last_col_n, last_row_n, last_piv_n, n_zero;

  assign accept = in_valid_i && in_ready_o;
  assign src_ok = 32'(src_i) < 32'(MAX_NODES);
  assign dst_ok = 32'(dst_i) < 32'(MAX_NODES);

  assign last_col_m = (col_q == LAST_IDX);
  assign last_row_m = (row_q == LAST_IDX);
  assign last_col_n = (CNT_W'(col_q) + 1'b1 == n_i);
  assign last_row_n = (CNT_W'(row_q) + 1'b1 == n_i);
  assign last_piv_n = (CNT_W'(piv_q) + 1'b1 == n_i);
  assign n_zero     = (n_i == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (last_row_m && last_col_m) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_e'(req_i))
            REQ_CLEAR:   state_d = ST_CLEAR;
            REQ_ADD:     state_d = (src_ok && dst_ok) ? ST_ADD1 : ST_IDLE;
            REQ_COMPUTE: state_d = ST_SEED1;
            REQ_QUERY:   state_d = ST_QUERY;
          endcase
        end
      end
      ST_CLEAR: begin
        if (last_row_m && last_col_m) state_d = ST_IDLE;
      end
      ST_ADD1: state_d = ST_ADD2;
      ST_ADD2: state_d = ST_IDLE;
      ST_SEED1: begin
        if (last_row_m && last_col_m) state_d = n_zero ? ST_SEED2 : ST_FETCH;
      end
      ST_SEED2: begin
        if (last_row_m && last_col_m) state_d = n_zero ? ST_IDLE : ST_FETCH;
      end
      ST_FETCH: state_d = ST_ROW;
      ST_ROW: begin
        if (last_col_n) begin
          if (last_row_n && last_piv_n) begin
            state_d = bank_q ? ST_IDLE : ST_SEED2;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_QUERY: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    piv_d  = piv_q;
    bank_d = bank_q;
    unique case (state_q)
      ST_INIT, ST_CLEAR, ST_SEED1, ST_SEED2: begin
        if (last_col_m) begin
          col_d = '0;
          row_d = last_row_m ? '0 : row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        if (state_q == ST_SEED2) bank_d = BANK_REACH;
      end
      ST_ROW: begin
        if (last_col_n) begin
          col_d = '0;
          if (last_row_n) begin
            row_d = '0;
            piv_d = last_piv_n ? '0 : piv_q + 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_IDLE: bank_d = BANK_SHORT;
      default: ;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ctrl_o.op       = DP_NONE;
    ctrl_o.bank     = bank_q;
    ctrl_o.in_range = 1'b1;
    row_o           = row_q;
    col_o           = col_q;
    piv_o           = piv_q;
    len_o           = len_q;
    unique case (state_q)
      ST_INIT:  ctrl_o.op = DP_INIT;
      ST_CLEAR: ctrl_o.op = DP_CLEAR;
      ST_ADD1: begin
        ctrl_o.op = DP_ADD;
        row_o     = NODE_W'(a_q);
        col_o     = NODE_W'(b_q);
      end
      ST_ADD2: begin
        ctrl_o.op = DP_ADD;
        row_o     = NODE_W'(b_q);
        col_o     = NODE_W'(a_q);
      end
      ST_SEED1, ST_SEED2: begin
        ctrl_o.op       = (state_q == ST_SEED1) ? DP_SEED1 : DP_SEED2;
        ctrl_o.in_range = (CNT_W'(row_q) < n_i) && (CNT_W'(col_q) < n_i);
      end
      ST_FETCH: ctrl_o.op = DP_FETCH;
      ST_ROW:   ctrl_o.op = DP_RELAX;
      ST_QUERY: begin
        ctrl_o.op       = out_stall_i ? DP_NONE : DP_QUERY;
        ctrl_o.in_range = ok_q;
        row_o           = NODE_W'(a_q);
        col_o           = NODE_W'(b_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      piv_q   <= '0;
      bank_q  <= BANK_SHORT;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      piv_q   <= piv_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= src_i;
      b_q   <= dst_i;
      len_q <= len_i;
      ok_q  <= src_ok && dst_ok;
    end
  end

  `TAPSP_ASSERT_IMPL(a_idle_counters_zero, state_q == ST_IDLE,
                     row_q == '0 && col_q == '0 && piv_q == '0,
                     "Loop counters are not back at zero in idle.")
  `TAPSP_ASSERT_IMPL(a_add_pair_order, state_q == ST_ADD2, $past(state_q) == ST_ADD1,
                     "Second edge write without the first.")

endmodule

@@ rtl/core/tapsp_datapath.sv @@
// Edge and distance memories with the shared saturating add and compare unit.
module tapsp_datapath #(
  parameter int MAX_NODES = tapsp_pkg::DEF_MAX_NODES,
  parameter int DIST_BITS = tapsp_pkg::DEF_DIST_BITS,
  parameter int NODE_W    = $clog2(MAX_NODES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tapsp_pkg::dp_ctrl_t            ctrl_i,
  input  logic [NODE_W-1:0]              row_i,
  input  logic [NODE_W-1:0]              col_i,
  input  logic [NODE_W-1:0]              piv_i,
  input  logic [tapsp_pkg::LEN_W-1:0]    len_i,
  input  logic [tapsp_pkg::THRESH_W-1:0] thresh_i,
  output tapsp_pkg::dp_result_t          res_o
);
  import tapsp_pkg::*;

  localparam int PAIRS      = MAX_NODES * MAX_NODES;
  localparam int PAIR_W     = $clog2(PAIRS);
  localparam int DIST_DEPTH = 2 * (1 << PAIR_W);
  localparam int CMP_W      = 33;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  logic [DIST_BITS-1:0] edge_mem [PAIRS];
  logic [DIST_BITS-1:0] dist_mem [DIST_DEPTH];

  logic [PAIR_W-1:0] p_rc, p_rk, p_kc;
  logic [PAIR_W-1:0] ea_a;
  logic [PAIR_W:0]   da_a, db_a, wa_a;
  logic [DIST_BITS-1:0] ev_a;

  dp_op_e            op_b_q;
  logic              inr_b_q;
  logic [PAIR_W-1:0] ea_b_q;
  logic [PAIR_W:0]   wa_b_q;
  logic [DIST_BITS-1:0] ev_b_q;
  logic [DIST_BITS-1:0] e_rd_q, a_rd_q, b_rd_q, ik_q;

  logic                 e_we, d_we;
  logic [DIST_BITS-1:0] e_wd, d_wd;
  logic [DIST_BITS:0]   relax_sum;
  logic [DIST_BITS-1:0] relax_d, q_d;
  logic                 short_ok, reach_ok;

  assign p_rc = PAIR_W'(row_i) * PAIR_W'(MAX_NODES) + PAIR_W'(col_i);
  assign p_rk = PAIR_W'(row_i) * PAIR_W'(MAX_NODES) + PAIR_W'(piv_i);
  assign p_kc = PAIR_W'(piv_i) * PAIR_W'(MAX_NODES) + PAIR_W'(col_i);
  assign ev_a = (CMP_W'(len_i) > CMP_W'(DIST_INF)) ? DIST_INF : DIST_BITS'(len_i);

  always_comb begin
    ea_a = p_rc;
    da_a = {ctrl_i.bank, p_rc};
    db_a = {ctrl_i.bank, p_rc};
    wa_a = {ctrl_i.bank, p_rc};
    unique case (ctrl_i.op)
      DP_INIT:  wa_a = {BANK_REACH, p_rc};
      DP_SEED1: wa_a = {BANK_SHORT, p_rc};
      DP_SEED2: begin
        da_a = {BANK_SHORT, p_rc};
        wa_a = {BANK_REACH, p_rc};
      end
      DP_FETCH: da_a = {ctrl_i.bank, p_rk};
      DP_RELAX: da_a = {ctrl_i.bank, p_kc};
      DP_QUERY: da_a = {BANK_REACH, p_rc};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_b_q <= DP_NONE;
    end else begin
      op_b_q <= ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    inr_b_q <= ctrl_i.in_range;
    ea_b_q  <= ea_a;
    wa_b_q  <= wa_a;
    ev_b_q  <= ev_a;
    if (op_b_q == DP_FETCH) ik_q <= a_rd_q;
  end

  always_ff @(posedge clk_i) begin
    e_rd_q <= edge_mem[ea_a];
    if (e_we) edge_mem[ea_b_q] <= e_wd;
  end

  always_ff @(posedge clk_i) begin
    a_rd_q <= dist_mem[da_a];
    b_rd_q <= dist_mem[db_a];
    if (d_we) dist_mem[wa_b_q] <= d_wd;
  end

  assign relax_sum = (DIST_BITS + 1)'(ik_q) + (DIST_BITS + 1)'(a_rd_q);
  assign relax_d   = (relax_sum >= (DIST_BITS + 1)'(DIST_INF)) ? DIST_INF
                                                              : relax_sum[DIST_BITS-1:0];
  assign short_ok  = inr_b_q && (e_rd_q != DIST_INF) &&
                     (CMP_W'(e_rd_q) <= CMP_W'(SHORT_EDGE_LIMIT));
  assign reach_ok  = inr_b_q && (e_rd_q != DIST_INF) &&
                     (CMP_W'(e_rd_q) <= CMP_W'(thresh_i)) && (a_rd_q != DIST_INF) &&
                     (CMP_W'(a_rd_q) <= (CMP_W'(thresh_i) << 1));
  assign q_d       = inr_b_q ? a_rd_q : DIST_INF;

  always_comb begin
    e_we               = 1'b0;
    e_wd               = DIST_INF;
    d_we               = 1'b0;
    d_wd               = DIST_INF;
    res_o.valid        = 1'b0;
    res_o.distance     = OUT_DIST_INF;
    res_o.reachable    = 1'b0;
    unique case (op_b_q)
      DP_INIT: begin
        e_we = 1'b1;
        d_we = 1'b1;
      end
      DP_CLEAR: e_we = 1'b1;
      DP_ADD: begin
        e_we = 1'b1;
        e_wd = ev_b_q;
      end
      DP_SEED1: begin
        d_we = 1'b1;
        d_wd = short_ok ? e_rd_q : DIST_INF;
      end
      DP_SEED2: begin
        d_we = 1'b1;
        d_wd = reach_ok ? e_rd_q : DIST_INF;
      end
      DP_RELAX: begin
        d_we = (relax_d < b_rd_q);
        d_wd = relax_d;
      end
      DP_QUERY: begin
        res_o.valid = 1'b1;
        if (q_d != DIST_INF && CMP_W'(q_d) <= CMP_W'(OUT_DIST_INF)) begin
          res_o.distance  = OUT_DIST_W'(q_d);
          res_o.reachable = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/thresholded_all_pairs_shortest_path_unit.sv @@
// Top level of the thresholded all-pairs shortest path unit.
`include "thresholded_all_pairs_shortest_path_unit_defines.svh"

// The unit holds an undirected edge store and a two-pass Floyd-Warshall closure over nodes
// 0 to node_count-1, all in unsigned Q8.8 with the all-ones value meaning unreachable, and
// takes one request at a time on the input stream. A query waits while the output register
// is full, then reads the reach bank and its result is registered at the output; an add edge
// writes both directions in turn through the single edge memory write port; a clear
// rewrites the edge store, one store entry a cycle. A compute seeds each of the two banks
// with a sweep over the whole pair store and closes it with, for each pivot and row, a fetch
// and then one relax per column through the shared saturating adder and comparator. After
// reset the unit runs a clearing pass over the whole pair store before it accepts a request;
// configuration writes are taken at any time.
module thresholded_all_pairs_shortest_path_unit #(
  parameter int MAX_NODES = tapsp_pkg::DEF_MAX_NODES,
  parameter int DIST_BITS = tapsp_pkg::DEF_DIST_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tapsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tapsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: src_node[5:0], dst_node[11:6], edge_length[27:12], zero fill.
  input  logic [tapsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [tapsp_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: distance[15:0].
  output logic [tapsp_pkg::OUT_DIST_W-1:0] m_axis_tdata,
  // Fields from bit 0: reachable[0].
  output logic                            m_axis_tuser
);
  import tapsp_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  logic [NCOUNT_W-1:0] node_count_q;
  logic [THRESH_W-1:0] thresh_q;
  logic [CNT_W-1:0]    n_eff;

  logic                  m_valid_q;
  logic [OUT_DIST_W-1:0] m_dist_q;
  logic                  m_reach_q;
  logic                  out_stall;

  dp_ctrl_t            ctrl;
  dp_result_t          dp_res;
  logic [NODE_W-1:0]   row, col, piv;
  logic [LEN_W-1:0]    len;

  assign n_eff = (32'(node_count_q) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                     : CNT_W'(node_count_q);
  assign out_stall = m_valid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      thresh_q     <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NODE_COUNT:      node_count_q <= NCOUNT_W'(cfg_wdata_i);
        CFG_REACH_THRESHOLD: thresh_q     <= THRESH_W'(cfg_wdata_i);
      endcase
    end
  end

  tapsp_seq #(
    .MAX_NODES(MAX_NODES),
    .NODE_W   (NODE_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (s_axis_tuser),
    .src_i      (s_axis_tdata[SRC_LSB +: NODE_IDX_W]),
    .dst_i      (s_axis_tdata[DST_LSB +: NODE_IDX_W]),
    .len_i      (s_axis_tdata[LEN_LSB +: LEN_W]),
    .n_i        (n_eff),
    .out_stall_i(out_stall),
    .ctrl_o     (ctrl),
    .row_o      (row),
    .col_o      (col),
    .piv_o      (piv),
    .len_o      (len)
  );

  tapsp_datapath #(
    .MAX_NODES(MAX_NODES),
    .DIST_BITS(DIST_BITS),
    .NODE_W   (NODE_W)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .row_i   (row),
    .col_i   (col),
    .piv_i   (piv),
    .len_i   (len),
    .thresh_i(thresh_q),
    .res_o   (dp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (dp_res.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_res.valid) begin
      m_dist_q  <= dp_res.distance;
      m_reach_q <= dp_res.reachable;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_dist_q;
  assign m_axis_tuser  = m_reach_q;

  `TAPSP_ASSERT_IMPL(a_result_slot_free, dp_res.valid, !m_valid_q,
                     "Query result arrived while the output register was still full.")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the thresholded all-pairs shortest path unit.
`timescale 1ns / 1ps

module tb_top;
  import tapsp_pkg::*;

  localparam int NODES       = DEF_MAX_NODES;
  localparam int PAIRS       = NODES * NODES;
  localparam int RANDOM_REQS = 550;
  localparam int QUIET_LIMIT = 2_200_000;
  localparam logic [LEN_W-1:0] INF = OUT_DIST_INF;

  typedef struct packed {
    req_type_e             kind;
    logic [NODE_IDX_W-1:0] src;
    logic [NODE_IDX_W-1:0] dst;
    logic [LEN_W-1:0]      len;
  } path_req_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] dist_val;
    logic                  reach;
  } dist_reply_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DIST_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  thresholded_all_pairs_shortest_path_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  path_req_t   req_backlog_q[$];
  dist_reply_t expected_dist_q[$];
  int          open_cnt    = 0;
  int          pushed_cnt  = 0;
  int          fail_cnt    = 0;
  int          quiet_cycles = 0;

  logic [LEN_W-1:0] edge_len_mem [PAIRS];
  logic [LEN_W-1:0] reach_mem    [PAIRS];
  logic [LEN_W-1:0] work_mem     [PAIRS];
  int unsigned      node_cfg;
  logic [THRESH_W-1:0] thr_cfg;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, INF}) ? INF : s[LEN_W-1:0];
  endfunction

  function automatic void close_work(int n);
    logic [LEN_W-1:0] d;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          d = sat_add(work_mem[i*NODES+k], work_mem[k*NODES+j]);
          if (d < work_mem[i*NODES+j]) work_mem[i*NODES+j] = d;
        end
  endfunction

  function automatic void run_compute();
    int n;
    logic [THRESH_W:0] lim2;
    logic [LEN_W-1:0] e;
    logic [LEN_W-1:0] s;
    n = (node_cfg > NODES) ? NODES : node_cfg;
    lim2 = {thr_cfg, 1'b0};
    for (int p = 0; p < PAIRS; p++) begin
      work_mem[p]  = INF;
      reach_mem[p] = INF;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e = edge_len_mem[i*NODES+j];
        if (e != INF && e <= SHORT_EDGE_LIMIT) work_mem[i*NODES+j] = e;
      end
    close_work(n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e = edge_len_mem[i*NODES+j];
        s = work_mem[i*NODES+j];
        if (e != INF && e <= thr_cfg && s != INF && {1'b0, s} <= lim2)
          reach_mem[i*NODES+j] = e;
      end
    for (int p = 0; p < PAIRS; p++) work_mem[p] = reach_mem[p];
    close_work(n);
    for (int p = 0; p < PAIRS; p++) reach_mem[p] = work_mem[p];
  endfunction

  function automatic bit apply_path_request(input path_req_t r, output dist_reply_t rep);
    logic [LEN_W-1:0] d;
    rep = '0;
    case (r.kind)
      REQ_CLEAR: begin
        for (int p = 0; p < PAIRS; p++) edge_len_mem[p] = INF;
        return 1'b0;
      end
      REQ_ADD: begin
        edge_len_mem[r.src*NODES+r.dst] = r.len;
        edge_len_mem[r.dst*NODES+r.src] = r.len;
        return 1'b0;
      end
      REQ_COMPUTE: begin
        run_compute();
        return 1'b0;
      end
      default: begin
        d = reach_mem[r.src*NODES+r.dst];
        rep.dist_val = d;
        rep.reach    = (d != INF);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void log_mismatch(string msg);
    if (fail_cnt < 10) $display("mismatch: %s", msg);
    fail_cnt++;
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void push_req(req_type_e kind, int src, int dst, int len);
    path_req_t r;
    r.kind = kind;
    r.src  = src[NODE_IDX_W-1:0];
    r.dst  = dst[NODE_IDX_W-1:0];
    r.len  = len[LEN_W-1:0];
    req_backlog_q = {req_backlog_q, r};
    pushed_cnt++;
    open_cnt++;
  endfunction

  function automatic int pick_node(int span);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, NODES - 1)
                                       : $urandom_range(0, span - 1);
  endfunction

  function automatic void push_edge(int span);
    int len;
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(0, 65535);
      1:       len = INF;
      default: len = $urandom_range(0, 700);
    endcase
    push_req(REQ_ADD, pick_node(span), pick_node(span), len);
  endfunction

  function automatic void push_query(int span);
    push_req(REQ_QUERY, pick_node(span), pick_node(span), $urandom_range(0, 65535));
  endfunction

  // Driver: one item in flight, a random gap drawn after each transfer.
  path_req_t drv_item = '0;
  int        tx_wait  = 0;
  bit        tx_burst = 1'b0;

  always @(posedge clk_i) begin
    logic        nv;
    dist_reply_t rep;
    nv = s_axis_tvalid;
    if (!rst_ni) begin
      nv = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (apply_path_request(drv_item, rep)) expected_dist_q = {expected_dist_q, rep};
        open_cnt--;
        nv = 1'b0;
        if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
        tx_wait = draw_wait(tx_burst);
      end
      if (!nv) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (req_backlog_q.size() != 0) begin
          drv_item = req_backlog_q.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= {4'b0, drv_item.len, drv_item.dst, drv_item.src};
    s_axis_tuser  <= drv_item.kind;
  end

  // Monitor: ready drops for a random stall after each transfer.
  int rx_wait  = 3;
  bit rx_burst = 1'b0;

  always @(posedge clk_i) begin
    dist_reply_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dist_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result %h/%b", m_axis_tdata, m_axis_tuser));
        end else begin
          exp_r = expected_dist_q.pop_front();
          if (m_axis_tdata !== exp_r.dist_val || m_axis_tuser !== exp_r.reach)
            log_mismatch($sformatf("distance/reachable expected %h/%b got %h/%b",
                                   exp_r.dist_val, exp_r.reach, m_axis_tdata, m_axis_tuser));
        end
        if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
        rx_wait = draw_wait(rx_burst);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic write_cfg(cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    if (idx == CFG_NODE_COUNT) node_cfg = value & 'h7F;
    else thr_cfg = value[THRESH_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Every phase ends with a query, so its result marks the unit as done.
  task automatic wait_drained();
    do @(negedge clk_i); while (open_cnt != 0 || expected_dist_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_random_phase();
    int n;
    int thr;
    int span;
    case ($urandom_range(0, 9))
      0:       n = 0;
      1:       n = $urandom_range(9, 16);
      default: n = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 9))
      0:       thr = 0;
      1:       thr = 65534;
      2:       thr = $urandom_range(0, 65534);
      default: thr = $urandom_range(100, 700);
    endcase
    write_cfg(CFG_NODE_COUNT, n);
    write_cfg(CFG_REACH_THRESHOLD, thr);
    span = (n == 0) ? 1 : n;
    if ($urandom_range(0, 2) == 0) push_req(REQ_CLEAR, 0, 0, 0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_query(span);
    repeat ($urandom_range(3, 14)) push_edge(span);
    if ($urandom_range(0, 4) == 0)
      push_req(req_type_e'($urandom_range(1, 3)), $urandom_range(0, 63),
               $urandom_range(0, 63), $urandom_range(0, 65535));
    push_req(REQ_COMPUTE, 0, 0, 0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) push_edge(span);
    repeat ($urandom_range(3, 12)) push_query(span);
  endtask

  initial begin
    int directed_cnt;
    node_cfg = NODE_COUNT_RST;
    thr_cfg  = THRESH_RST;
    for (int p = 0; p < PAIRS; p++) begin
      edge_len_mem[p] = INF;
      reach_mem[p]    = INF;
      work_mem[p]     = INF;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short-edge limit boundary, zero length, self-loop, all-ones edge length, far nodes.
    write_cfg(CFG_NODE_COUNT, 4);
    write_cfg(CFG_REACH_THRESHOLD, 65534);
    push_req(REQ_QUERY, 0, 1, 0);
    push_req(REQ_ADD, 0, 1, 258);
    push_req(REQ_ADD, 1, 2, 259);
    push_req(REQ_ADD, 2, 3, 0);
    push_req(REQ_ADD, 3, 3, 100);
    push_req(REQ_ADD, 0, 2, INF);
    push_req(REQ_ADD, 63, 62, 65534);
    push_req(REQ_COMPUTE, 0, 0, 0);
    push_req(REQ_QUERY, 0, 3, 0);
    push_req(REQ_QUERY, 3, 3, 0);
    push_req(REQ_QUERY, 63, 62, 0);
    push_req(REQ_QUERY, 1, 2, 0);
    wait_drained();

    // A zero node count only wipes the distances.
    write_cfg(CFG_NODE_COUNT, 0);
    write_cfg(CFG_REACH_THRESHOLD, 0);
    push_req(REQ_COMPUTE, 0, 0, 0);
    push_req(REQ_QUERY, 0, 1, 0);
    wait_drained();

    // An oversized node count saturates; a clear keeps the distances.
    write_cfg(CFG_NODE_COUNT, 127);
    write_cfg(CFG_REACH_THRESHOLD, 300);
    push_req(REQ_CLEAR, 0, 0, 0);
    push_req(REQ_ADD, 10, 20, 258);
    push_req(REQ_ADD, 20, 30, 200);
    push_req(REQ_ADD, 30, 10, 290);
    push_req(REQ_ADD, 63, 0, 5);
    push_req(REQ_COMPUTE, 0, 0, 0);
    push_req(REQ_QUERY, 10, 30, 0);
    push_req(REQ_QUERY, 63, 0, 0);
    push_req(REQ_CLEAR, 0, 0, 0);
    push_req(REQ_QUERY, 30, 10, 0);
    wait_drained();

    directed_cnt = pushed_cnt;
    while (pushed_cnt < directed_cnt + RANDOM_REQS) begin
      queue_random_phase();
      wait_drained();
    end
    repeat (16) @(posedge clk_i);

    if (expected_dist_q.size() != 0) log_mismatch("results still outstanding at end");
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tapsp_pkg.sv
rtl/core/tapsp_seq.sv
rtl/core/tapsp_datapath.sv
rtl/core/thresholded_all_pairs_shortest_path_unit.sv
dv/tb_top.sv
